// ===== src/rpwc_pkg.sv =====
`default_nettype none
package rpwc_pkg;

	localparam int TIME_W  = 32;
	localparam int IDX_W   = 7;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;
	localparam int PCNT_W  = 8;
	localparam int CFG_W   = 32;
	localparam int CFGI_W  = 2;
	localparam int STORE_DEPTH_DEF = 128;

	typedef logic [OP_W-1:0]   opcode_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic [CFGI_W-1:0] cfg_idx_t;

	localparam opcode_t OP_RISE  = 3'd0;
	localparam opcode_t OP_FALL  = 3'd1;
	localparam opcode_t OP_POLL  = 3'd2;
	localparam opcode_t OP_READ  = 3'd3;
	localparam opcode_t OP_REARM = 3'd4;

	localparam status_t ST_IDLE    = 2'd0;
	localparam status_t ST_RECV    = 2'd1;
	localparam status_t ST_DONE    = 2'd2;
	localparam status_t ST_TIMEOUT = 2'd3;

	localparam cfg_idx_t REG_MAX_SIGNAL = 2'd0;
	localparam cfg_idx_t REG_MIN_PULSES = 2'd1;
	localparam cfg_idx_t REG_TIMEOUT_US = 2'd2;
	localparam cfg_idx_t REG_MAX_PAIRS  = 2'd3;

	localparam logic [31:0] MAX_SIGNAL_RST = 32'd5000;
	localparam logic [7:0]  MIN_PULSES_RST = 8'd10;
	localparam logic [31:0] TIMEOUT_US_RST = 32'd100000;
	localparam logic [7:0]  MAX_PAIRS_RST  = 8'd127;

endpackage
`default_nettype wire

// ===== src/rpwc_cmd_if.sv =====
`default_nettype none
interface rpwc_cmd_if;
	import rpwc_pkg::*;

	logic                valid;
	logic                ready;
	opcode_t             opcode;
	logic [TIME_W-1:0]   time_us;
	logic [IDX_W-1:0]    read_index;

	modport source (output valid, output opcode, output time_us, output read_index,
		input ready);
	modport sink (input valid, input opcode, input time_us, input read_index,
		output ready);
endinterface
`default_nettype wire

// ===== src/rpwc_rsp_if.sv =====
`default_nettype none
interface rpwc_rsp_if;
	import rpwc_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	logic [PCNT_W-1:0]   pair_count;
	logic [TIME_W-1:0]   low_width;
	logic [TIME_W-1:0]   high_width;

	modport source (output valid, output status, output pair_count, output low_width,
		output high_width, input ready);
	modport sink (input valid, input status, input pair_count, input low_width,
		input high_width, output ready);
endinterface
`default_nettype wire

// ===== src/radio_pulse_width_capture_top.sv =====
// A result word is registered in s1 at the edge that accepts its command word, then moves
//   on to the output register.
// Throughput: one command word per cycle while results are taken; every op is one
//   read-modify-write of the state registers plus at most one write to each pulse store, one port each.
// A stalled result holds the output register; s1 takes one more word, then cmd.ready drops.
// Reset (arst_n low): capture idle, counts and edge state cleared, config registers
//   to defaults; pulse stores are not cleared and hold garbage until written.
`default_nettype none
module radio_pulse_width_capture_top #(
	parameter int STORE_DEPTH = rpwc_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	rpwc_cmd_if.sink                         cmd,
	rpwc_rsp_if.source                       rsp,
	input  wire logic                        cfg_we,
	input  wire rpwc_pkg::cfg_idx_t          cfg_index,
	input  wire logic [rpwc_pkg::CFG_W-1:0]  cfg_data
);
	import rpwc_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

	// config
	logic [31:0] max_signal_q;
	logic [7:0]  min_pulses_q;
	logic [31:0] timeout_us_q;
	logic [7:0]  max_pairs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_signal_q <= MAX_SIGNAL_RST;
			min_pulses_q <= MIN_PULSES_RST;
			timeout_us_q <= TIMEOUT_US_RST;
			max_pairs_q  <= MAX_PAIRS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_SIGNAL: max_signal_q <= cfg_data;
				REG_MIN_PULSES: min_pulses_q <= cfg_data[7:0];
				REG_TIMEOUT_US: timeout_us_q <= cfg_data;
				REG_MAX_PAIRS:  max_pairs_q  <= cfg_data[7:0];
			endcase
		end
	end

	// capture state
	status_t         status_q;
	logic [31:0]     last_edge_q;
	logic            edge_valid_q;
	logic [31:0]     msg_start_q;
	logic [CW-1:0]   low_cnt_q;
	logic [CW-1:0]   high_cnt_q;

	// pipeline
	logic                 v_s1;
	status_t              status_s1;
	logic [PCNT_W-1:0]    pcnt_s1;
	logic                 rd_s1;
	logic                 out_v_q;
	status_t              status_out_q;
	logic [PCNT_W-1:0]    pcnt_q;
	logic [TIME_W-1:0]    low_q;
	logic [TIME_W-1:0]    high_q;

	logic adv;
	logic fire;

	assign adv       = !out_v_q || rsp.ready;
	assign cmd.ready = !v_s1 || adv;
	assign fire      = cmd.valid && cmd.ready;

	// next-state logic
	logic [31:0]   delta;
	logic          long_gap;
	status_t       nxt_status;
	logic [31:0]   nxt_last;
	logic          nxt_valid;
	logic [31:0]   nxt_start;
	logic [CW-1:0] nxt_lcnt;
	logic [CW-1:0] nxt_hcnt;
	logic          low_we;
	logic [AW-1:0] low_waddr;
	logic [31:0]   low_wdata;
	logic          high_we;
	logic [AW-1:0] high_waddr;
	logic [31:0]   high_wdata;
	logic          rd_en;
	logic          rd_in_range;
	logic [AW-1:0] raddr;

	assign delta       = cmd.time_us - last_edge_q;
	assign long_gap    = delta > max_signal_q;
	assign rd_in_range = 32'(cmd.read_index) < 32'(STORE_DEPTH);
	assign raddr       = AW'(cmd.read_index);
	assign rd_en       = fire && (cmd.opcode == OP_READ) && rd_in_range;

	always_comb begin
		nxt_status = status_q;
		nxt_last   = last_edge_q;
		nxt_valid  = edge_valid_q;
		nxt_start  = msg_start_q;
		nxt_lcnt   = low_cnt_q;
		nxt_hcnt   = high_cnt_q;
		low_we     = 1'b0;
		low_waddr  = low_cnt_q[AW-1:0];
		low_wdata  = delta;
		high_we    = 1'b0;
		high_waddr = high_cnt_q[AW-1:0];
		high_wdata = delta;

		unique case (cmd.opcode)
			OP_RISE: begin
				if (status_q == ST_IDLE || status_q == ST_RECV) begin
					nxt_last  = cmd.time_us;
					nxt_valid = 1'b1;
				end
				if ((status_q == ST_IDLE && long_gap && edge_valid_q) ||
					(status_q == ST_RECV && long_gap &&
					32'(low_cnt_q) < 32'(min_pulses_q))) begin
					// new message, first low width seeded with max_signal
					nxt_status = ST_RECV;
					nxt_start  = cmd.time_us;
					nxt_hcnt   = '0;
					nxt_lcnt   = CW'(1);
					low_we     = 1'b1;
					low_waddr  = '0;
					low_wdata  = max_signal_q;
				end else if (status_q == ST_RECV) begin
					if (long_gap) begin
						nxt_status = ST_DONE;
						low_wdata  = '0;
					end
					if (low_cnt_q < DEPTH_C) begin
						low_we   = 1'b1;
						nxt_lcnt = low_cnt_q + CW'(1);
					end
				end
			end
			OP_FALL: begin
				if (status_q == ST_IDLE || status_q == ST_RECV) begin
					nxt_last  = cmd.time_us;
					nxt_valid = 1'b1;
				end
				if (status_q == ST_RECV && high_cnt_q < DEPTH_C) begin
					high_we  = 1'b1;
					nxt_hcnt = high_cnt_q + CW'(1);
				end
			end
			OP_POLL: begin
				if (status_q == ST_RECV &&
					((cmd.time_us - msg_start_q) > timeout_us_q ||
					32'(high_cnt_q) > 32'(max_pairs_q))) begin
					nxt_status = ST_TIMEOUT;
				end
			end
			OP_REARM: begin
				nxt_status = ST_IDLE;
				nxt_last   = '0;
				nxt_valid  = 1'b0;
				nxt_lcnt   = '0;
				nxt_hcnt   = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= ST_IDLE;
			last_edge_q  <= '0;
			edge_valid_q <= 1'b0;
			msg_start_q  <= '0;
			low_cnt_q    <= '0;
			high_cnt_q   <= '0;
		end else if (fire) begin
			status_q     <= nxt_status;
			last_edge_q  <= nxt_last;
			edge_valid_q <= nxt_valid;
			msg_start_q  <= nxt_start;
			low_cnt_q    <= nxt_lcnt;
			high_cnt_q   <= nxt_hcnt;
		end
	end

	// pulse stores
	logic [31:0] low_rdata;
	logic [31:0] high_rdata;

	rpwc_ram #(
		.WIDTH (TIME_W),
		.DEPTH (STORE_DEPTH)
	) u_low_store (
		.clk   (clk),
		.we    (fire && low_we),
		.waddr (low_waddr),
		.wdata (low_wdata),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (low_rdata)
	);

	rpwc_ram #(
		.WIDTH (TIME_W),
		.DEPTH (STORE_DEPTH)
	) u_high_store (
		.clk   (clk),
		.we    (fire && high_we),
		.waddr (high_waddr),
		.wdata (high_wdata),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (high_rdata)
	);

	// result pipeline; store read data is held while s1 stalls since no read is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (fire) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s1 <= nxt_status;
			pcnt_s1   <= PCNT_W'(nxt_hcnt);
			rd_s1     <= rd_en;
		end
		if (adv && v_s1) begin
			status_out_q <= status_s1;
			pcnt_q       <= pcnt_s1;
			low_q        <= rd_s1 ? low_rdata : '0;
			high_q       <= rd_s1 ? high_rdata : '0;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.status     = status_out_q;
	assign rsp.pair_count = pcnt_q;
	assign rsp.low_width  = low_q;
	assign rsp.high_width = high_q;

	// checks
	a_low_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		low_cnt_q <= DEPTH_C && high_cnt_q <= DEPTH_C)
		else $error("pulse count beyond store depth");

	a_recv_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		status_q == ST_RECV |-> low_cnt_q != '0)
		else $error("receiving without seeded low width");

	a_rdata_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && rd_s1 && !adv |=> $stable(low_rdata) && $stable(high_rdata))
		else $error("store read data changed under a stalled word");

	a_stall_no_fire: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !rsp.ready |=> out_v_q)
		else $error("result word dropped while stalled");

endmodule
`default_nettype wire

// ===== src/rpwc_ram.sv =====
`default_nettype none
module rpwc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== bench/radio_pulse_width_capture_top_tb.sv =====
`default_nettype none
module radio_pulse_width_capture_top_tb;
	import rpwc_pkg::*;

	localparam int DEPTH = STORE_DEPTH_DEF;
	localparam int LIMIT = 400000;
	localparam int HOLD_CYCLES = 60;
	localparam opcode_t OP_SPARE = 3'd7;

	typedef struct packed {
		status_t     status;
		logic [7:0]  pair_count;
		logic [31:0] low_width;
		logic [31:0] high_width;
	} capture_word_t;

	typedef struct packed {
		opcode_t       op;
		logic [31:0]   t;
		logic [6:0]    idx;
		bit            typed;
		capture_word_t want;
	} dir_row_t;

	localparam capture_word_t NO_WORD = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_data;

	rpwc_cmd_if cmd_bus();
	rpwc_rsp_if rsp_bus();

	radio_pulse_width_capture_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.rsp(rsp_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// predicted capture state
	logic [31:0] cfg_max_signal, cfg_timeout;
	logic [7:0]  cfg_min_pulses, cfg_max_pairs;
	status_t     cap_state;
	logic [31:0] cap_last, cap_start;
	bit          cap_edge_ok;
	int          low_cnt, high_cnt;
	logic [31:0] low_mem [DEPTH];
	logic [31:0] high_mem [DEPTH];
	int          lo_hw, hi_hw;

	capture_word_t pending_words [$];
	dir_row_t      dir_tab [25];

	int  fail_cnt, words_sent, reads_sent, msgs_done, msgs_cut, cyc;
	bit  cmd_live, burst, calm, long_hold;

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic void store_low(input logic [31:0] w);
		if (low_cnt < DEPTH) begin
			low_mem[low_cnt] = w;
			low_cnt++;
			if (low_cnt > lo_hw) lo_hw = low_cnt;
		end
	endfunction

	function automatic void store_high(input logic [31:0] w);
		if (high_cnt < DEPTH) begin
			high_mem[high_cnt] = w;
			high_cnt++;
			if (high_cnt > hi_hw) hi_hw = high_cnt;
		end
	endfunction

	function automatic void open_message(input logic [31:0] now);
		low_cnt = 0;
		high_cnt = 0;
		cap_state = ST_RECV;
		cap_start = now;
		store_low(cfg_max_signal);
	endfunction

	function automatic void clear_capture();
		cap_state = ST_IDLE;
		cap_last = '0;
		cap_edge_ok = 1'b0;
		low_cnt = 0;
		high_cnt = 0;
	endfunction

	function automatic capture_word_t predict_capture(input opcode_t op, input logic [31:0] now,
			input logic [6:0] idx);
		capture_word_t r;
		logic [31:0] delta;
		bit gap_long;
		r = '0;
		delta = now - cap_last;
		gap_long = delta > cfg_max_signal;
		case (op)
			OP_RISE: begin
				if (cap_state == ST_IDLE || cap_state == ST_RECV) begin
					if (cap_state == ST_IDLE) begin
						if (gap_long && cap_edge_ok) open_message(now);
					end else if (gap_long) begin
						if (low_cnt < cfg_min_pulses) begin
							open_message(now);
						end else begin
							store_low('0);
							cap_state = ST_DONE;
							msgs_done++;
						end
					end else begin
						store_low(delta);
					end
					cap_last = now;
					cap_edge_ok = 1'b1;
				end
			end
			OP_FALL: begin
				if (cap_state == ST_IDLE || cap_state == ST_RECV) begin
					if (cap_state == ST_RECV) store_high(delta);
					cap_last = now;
					cap_edge_ok = 1'b1;
				end
			end
			OP_POLL: begin
				if (cap_state == ST_RECV &&
						((now - cap_start) > cfg_timeout || high_cnt > cfg_max_pairs)) begin
					cap_state = ST_TIMEOUT;
					msgs_cut++;
				end
			end
			OP_READ: begin
				reads_sent++;
				if (idx < DEPTH) begin
					r.low_width = low_mem[idx];
					r.high_width = high_mem[idx];
				end
			end
			OP_REARM: clear_capture();
			default: ;
		endcase
		r.status = cap_state;
		r.pair_count = 8'(high_cnt);
		return r;
	endfunction

	function automatic void check_word(input capture_word_t got);
		capture_word_t want;
		if (pending_words.size() == 0) begin
			$error("result word with nothing pending");
			fail_cnt++;
			return;
		end
		want = pending_words.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			fail_cnt++;
		end
		if (got.pair_count !== want.pair_count) begin
			$error("pair_count: expected %0d, got %0d", want.pair_count, got.pair_count);
			fail_cnt++;
		end
		if (got.low_width !== want.low_width) begin
			$error("low_width: expected %0d, got %0d", want.low_width, got.low_width);
			fail_cnt++;
		end
		if (got.high_width !== want.high_width) begin
			$error("high_width: expected %0d, got %0d", want.high_width, got.high_width);
			fail_cnt++;
		end
	endfunction

	task automatic cmd_idle();
		if (cmd_live) begin
			cmd_bus.valid <= 1'b0;
			cmd_live = 1'b0;
		end
	endtask

	task automatic drain();
		cmd_idle();
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	task automatic send_word(input opcode_t op, input logic [31:0] t, input logic [6:0] idx,
			input bit typed, input capture_word_t given);
		int gap;
		bit ok;
		capture_word_t w;
		gap = (calm || burst) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			if (cmd_live) cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.opcode <= op;
		cmd_bus.time_us <= t;
		cmd_bus.read_index <= idx;
		cmd_live = 1'b1;
		do begin
			@(negedge clk);
			ok = cmd_bus.ready;
			@(posedge clk);
		end while (!ok);
		w = predict_capture(op, t, idx);
		pending_words.push_back(typed ? given : w);
		words_sent++;
	endtask

	task automatic set_config(input logic [31:0] ms, input logic [7:0] mp,
			input logic [31:0] to, input logic [7:0] mx);
		logic [31:0] vals [4];
		cfg_idx_t regs [4];
		vals = '{ms, {24'd0, mp}, to, {24'd0, mx}};
		regs = '{REG_MAX_SIGNAL, REG_MIN_PULSES, REG_TIMEOUT_US, REG_MAX_PAIRS};
		drain();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg_max_signal = ms;
		cfg_min_pulses = mp;
		cfg_timeout = to;
		cfg_max_pairs = mx;
	endtask

	function automatic logic [6:0] pick_idx();
		return 7'($urandom_range(0, 127));
	endfunction

	function automatic logic [31:0] pick_short();
		logic [31:0] top;
		top = (cfg_max_signal < 32'd3000) ? cfg_max_signal : 32'd3000;
		if ($urandom_range(0, 7) == 0) return cfg_max_signal;
		return $urandom_range(0, top);
	endfunction

	function automatic logic [31:0] pick_long();
		logic [31:0] d;
		d = cfg_max_signal + 32'd1 + $urandom_range(0, 2000);
		if (d <= cfg_max_signal) d = cfg_max_signal + 32'd1;
		return d;
	endfunction

	function automatic int pick_pairs();
		int top;
		top = (cfg_min_pulses > 30) ? 30 : int'(cfg_min_pulses);
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 40);
		return $urandom_range(0, top + 3);
	endfunction

	task automatic send_edge(input opcode_t op, input logic [31:0] d);
		send_word(op, cap_last + d, pick_idx(), 1'b0, NO_WORD);
	endtask

	task automatic poll_word();
		logic [31:0] t;
		case ($urandom_range(0, 2))
			0: t = cap_start + cfg_timeout;
			1: t = cap_start + cfg_timeout + 32'd1;
			default: t = cap_last + pick_short();
		endcase
		send_word(OP_POLL, t, pick_idx(), 1'b0, NO_WORD);
	endtask

	// only entries written since reset are read back; stores fill from index 0 up
	task automatic read_word();
		int n;
		logic [6:0] idx;
		n = (lo_hw < hi_hw) ? lo_hw : hi_hw;
		if (n == 0) begin
			poll_word();
		end else begin
			idx = ($urandom_range(0, 3) == 0) ? 7'(n - 1) : 7'($urandom_range(0, n - 1));
			send_word(OP_READ, $urandom, idx, 1'b0, NO_WORD);
		end
	endtask

	task automatic noise_word();
		opcode_t op;
		op = opcode_t'($urandom_range(0, 7));
		if (op == OP_READ)
			read_word();
		else if ($urandom_range(0, 1) == 0)
			send_word(op, $urandom, pick_idx(), 1'b0, NO_WORD);
		else
			send_edge(op, pick_long());
	endtask

	task automatic one_message(input int pairs, input bit clean);
		int r;
		if (cap_state == ST_DONE || cap_state == ST_TIMEOUT) begin
			if (!clean && $urandom_range(0, 3) == 0) send_edge(OP_RISE, pick_long());
			send_word(OP_REARM, $urandom, pick_idx(), 1'b0, NO_WORD);
		end
		if (!cap_edge_ok) send_edge($urandom_range(0, 1) ? OP_RISE : OP_FALL, $urandom);
		if (cap_state == ST_IDLE) send_edge(OP_RISE, pick_long());
		for (int k = 0; k < pairs; k++) begin
			send_edge(OP_FALL, pick_short());
			if (!clean) begin
				r = $urandom_range(0, 99);
				if (r < 6) poll_word();
				else if (r < 10) read_word();
				else if (r < 12) noise_word();
			end
			send_edge(OP_RISE, pick_short());
		end
		r = $urandom_range(0, 99);
		if (r < 60) send_edge(OP_RISE, pick_long());
		else if (r < 85) poll_word();
	endtask

	task automatic random_phase(input int n, input bit msgs);
		int stop, r;
		stop = words_sent + n;
		while (words_sent < stop) begin
			r = $urandom_range(0, 99);
			if (msgs && r < 70) one_message(pick_pairs(), 1'b0);
			else if (r < 85) read_word();
			else noise_word();
		end
	endtask

	initial begin : rx_side
		int w;
		bit got;
		capture_word_t seen;
		rsp_bus.ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				rsp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			w = calm ? 0 : $urandom_range(0, 8);
			if (w > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do begin
				@(negedge clk);
				got = rsp_bus.valid;
				seen.status = rsp_bus.status;
				seen.pair_count = rsp_bus.pair_count;
				seen.low_width = rsp_bus.low_width;
				seen.high_width = rsp_bus.high_width;
				@(posedge clk);
			end while (!got);
			check_word(seen);
		end
	end

	initial begin : tx_side
		cmd_bus.valid = 1'b0;
		cmd_bus.opcode = OP_POLL;
		cmd_bus.time_us = '0;
		cmd_bus.read_index = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MAX_SIGNAL;
		cfg_data = '0;
		cfg_max_signal = MAX_SIGNAL_RST;
		cfg_min_pulses = MIN_PULSES_RST;
		cfg_timeout = TIMEOUT_US_RST;
		cfg_max_pairs = MAX_PAIRS_RST;
		clear_capture();
		cap_start = '0;

		// directed config: max_signal 100, min_pulses 2, timeout 1000, max_pairs 3
		dir_tab = '{
			'{OP_POLL,  32'd0,          7'd0,   1'b1, '{ST_IDLE, 8'd0, 32'd0, 32'd0}},
			'{OP_RISE,  32'd0,          7'd0,   1'b1, '{ST_IDLE, 8'd0, 32'd0, 32'd0}},
			'{OP_FALL,  32'd50,         7'd1,   1'b1, '{ST_IDLE, 8'd0, 32'd0, 32'd0}},
			'{OP_RISE,  32'd500,        7'd2,   1'b1, '{ST_RECV, 8'd0, 32'd0, 32'd0}},
			'{OP_FALL,  32'd520,        7'd4,   1'b0, NO_WORD},
			'{OP_RISE,  32'd530,        7'd8,   1'b0, NO_WORD},
			'{OP_FALL,  32'd600,        7'd16,  1'b0, NO_WORD},
			'{OP_READ,  32'd610,        7'd0,   1'b0, NO_WORD},
			'{OP_RISE,  32'd2000,       7'd32,  1'b0, NO_WORD},
			'{OP_RISE,  32'd2010,       7'd64,  1'b0, NO_WORD},
			'{OP_READ,  32'd2020,       7'd1,   1'b0, NO_WORD},
			'{OP_REARM, 32'd2030,       7'd0,   1'b1, '{ST_IDLE, 8'd0, 32'd0, 32'd0}},
			'{OP_RISE,  32'hFFFF_FFF0,  7'd0,   1'b1, '{ST_IDLE, 8'd0, 32'd0, 32'd0}},
			'{OP_RISE,  32'h0000_0100,  7'd0,   1'b1, '{ST_RECV, 8'd0, 32'd0, 32'd0}},
			'{OP_RISE,  32'h0000_1000,  7'd0,   1'b0, NO_WORD},
			'{OP_POLL,  32'h0000_1BB8,  7'd0,   1'b0, NO_WORD},
			'{OP_SPARE, 32'hFFFF_FFFF,  7'd127, 1'b1, '{ST_TIMEOUT, 8'd0, 32'd0, 32'd0}},
			'{OP_REARM, 32'd0,          7'd0,   1'b1, '{ST_IDLE, 8'd0, 32'd0, 32'd0}},
			'{OP_RISE,  32'd10,         7'd0,   1'b1, '{ST_IDLE, 8'd0, 32'd0, 32'd0}},
			'{OP_RISE,  32'd1000,       7'd0,   1'b1, '{ST_RECV, 8'd0, 32'd0, 32'd0}},
			'{OP_FALL,  32'd1010,       7'd0,   1'b0, NO_WORD},
			'{OP_FALL,  32'd1020,       7'd0,   1'b0, NO_WORD},
			'{OP_FALL,  32'd1030,       7'd0,   1'b0, NO_WORD},
			'{OP_FALL,  32'd1040,       7'd0,   1'b0, NO_WORD},
			'{OP_POLL,  32'd1050,       7'd0,   1'b0, NO_WORD}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(32'd100, 8'd2, 32'd1000, 8'd3);
		foreach (dir_tab[i])
			send_word(dir_tab[i].op, dir_tab[i].t, dir_tab[i].idx, dir_tab[i].typed,
				dir_tab[i].want);

		set_config(MAX_SIGNAL_RST, MIN_PULSES_RST, TIMEOUT_US_RST, MAX_PAIRS_RST);
		random_phase(120, 1'b1);
		// back-to-back words against a stalled result side
		burst = 1'b1;
		long_hold = 1'b1;
		random_phase(40, 1'b1);
		burst = 1'b0;
		random_phase(140, 1'b1);

		set_config(32'd1, 8'd0, 32'd1, 8'd1);
		random_phase(100, 1'b1);
		drain();
		random_phase(100, 1'b1);

		// one message long enough to overflow both stores
		set_config(32'd200, 8'd128, 32'hFFFF_FFFF, 8'd128);
		send_word(OP_REARM, $urandom, pick_idx(), 1'b0, NO_WORD);
		one_message(135, 1'b1);
		random_phase(100, 1'b1);

		set_config(32'hFFFF_FFFF, 8'd0, 32'd1, 8'd1);
		random_phase(60, 1'b0);

		set_config($urandom_range(1, 3000), 8'($urandom_range(0, 20)),
			$urandom_range(1, 200000), 8'($urandom_range(1, 20)));
		calm = 1'b1;
		random_phase(60, 1'b1);
		calm = 1'b0;
		random_phase(120, 1'b1);

		drain();
		repeat (10) @(posedge clk);
		$display("covered %0d command words over six register settings: %0d reads,",
			words_sent, reads_sent);
		$display("%0d messages completed, %0d cut off, stores reached %0d/%0d entries",
			msgs_done, msgs_cut, lo_hw, hi_hw);
		if (fail_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
